@@ src/cpd_pkg.sv @@
// Shared types and constants for the COBS packet deframer.
`default_nettype none
package cpd_pkg;

  localparam int HEADER_BYTES = 11;
  localparam int COUNT_BITS = 18;
  localparam int TYPE_BYTE_INDEX = 0;
  localparam int LEN_FIRST_INDEX = 7;
  localparam int LEN_LAST_INDEX = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam int TYPE_W = 8;
  localparam int MAX_PAYLOAD_W = 17;
  localparam int MAX_ENCODED_W = 18;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int LENGTH_W = 32;

  localparam logic [TYPE_W-1:0] EXPECTED_TYPE_RESET = 8'h01;
  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 17'(120 * 1024);
  localparam logic [MAX_ENCODED_W-1:0] MAX_ENCODED_RESET = 18'(120 * 1024 + 256);

  localparam logic [7:0] DELIMITER = 8'h00;
  localparam logic [7:0] FULL_BLOCK_CODE = 8'hFF;
  localparam logic [7:0] CODE_STEP = 8'h01;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_TYPE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ENCODED = 2'd2;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_SHORT      = 2'd1,
    ST_BAD_HEADER = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_END_DELIM,
    CMD_END_OVF
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       truncated;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

@@ src/cpd_front.sv @@
// Front end: COBS code tracking, overflow check and command generation.
`default_nettype none
module cpd_front #(
  parameter int COUNT_BITS = cpd_pkg::COUNT_BITS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   rx_valid,
  input  wire  [7:0]                            rx_byte,
  input  wire  [cpd_pkg::MAX_ENCODED_W-1:0]     max_encoded,
  input  cpd_pkg::q_status_t                    q_status,
  output logic                                  push,
  output cpd_pkg::cmd_t                         cmd
);

  localparam int CMP_W = (COUNT_BITS > cpd_pkg::MAX_ENCODED_W) ?
                         COUNT_BITS : cpd_pkg::MAX_ENCODED_W;

  logic [COUNT_BITS-1:0] encoded_count;
  logic [COUNT_BITS-1:0] encoded_count_next;
  logic [7:0]            block_remaining;
  logic [7:0]            block_remaining_next;
  logic                  pending_zero;
  logic                  pending_zero_next;
  logic                  accept;
  logic                  overflow;

  assign accept = rx_valid && !q_status.full;
  assign overflow = (CMP_W'(encoded_count) >= CMP_W'(max_encoded)) || (&encoded_count);

  always_comb begin
    encoded_count_next   = encoded_count;
    block_remaining_next = block_remaining;
    pending_zero_next    = pending_zero;
    push                 = 1'b0;
    cmd.kind             = cpd_pkg::CMD_DATA;
    cmd.truncated        = 1'b0;
    cmd.data             = 8'h00;
    if (accept) begin
      if (rx_byte == cpd_pkg::DELIMITER) begin
        push                 = 1'b1;
        cmd.kind             = cpd_pkg::CMD_END_DELIM;
        cmd.truncated        = (block_remaining != 8'h00);
        encoded_count_next   = '0;
        block_remaining_next = 8'h00;
        pending_zero_next    = 1'b0;
      end else if (overflow) begin
        push                 = 1'b1;
        cmd.kind             = cpd_pkg::CMD_END_OVF;
        encoded_count_next   = '0;
        block_remaining_next = 8'h00;
        pending_zero_next    = 1'b0;
      end else begin
        encoded_count_next = encoded_count + COUNT_BITS'(1);
        if (block_remaining == 8'h00) begin
          push                 = pending_zero;
          block_remaining_next = rx_byte - cpd_pkg::CODE_STEP;
          pending_zero_next    = (rx_byte != cpd_pkg::FULL_BLOCK_CODE);
        end else begin
          push                 = 1'b1;
          cmd.data             = rx_byte;
          block_remaining_next = block_remaining - cpd_pkg::CODE_STEP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encoded_count   <= '0;
      block_remaining <= 8'h00;
      pending_zero    <= 1'b0;
    end else begin
      encoded_count   <= encoded_count_next;
      block_remaining <= block_remaining_next;
      pending_zero    <= pending_zero_next;
    end
  end

endmodule
`default_nettype wire

@@ src/cpd_queue.sv @@
// Command queue between the front end and the back end.
`default_nettype none
module cpd_queue #(
  parameter int DEPTH = cpd_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  cpd_pkg::cmd_t       push_cmd,
  input  wire                 pop,
  output cpd_pkg::cmd_t       pop_cmd,
  output cpd_pkg::q_status_t  q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpd_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/cpd_back.sv @@
// Back end: header capture, status evaluation and result register.
`default_nettype none
module cpd_back #(
  parameter int COUNT_BITS = cpd_pkg::COUNT_BITS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  cpd_pkg::cmd_t                         cmd,
  input  cpd_pkg::q_status_t                    q_status,
  output logic                                  pop,
  input  wire  [cpd_pkg::TYPE_W-1:0]            expected_type,
  input  wire  [cpd_pkg::MAX_PAYLOAD_W-1:0]     max_payload,
  output logic                                  res_valid,
  input  wire                                   res_stall,
  output logic                                  is_end,
  output logic [7:0]                            data_byte,
  output logic [1:0]                            status,
  output logic [cpd_pkg::LENGTH_W-1:0]          payload_length
);

  localparam int SUM_W = cpd_pkg::LENGTH_W + 1;

  logic [COUNT_BITS-1:0]          decoded_count;
  logic [COUNT_BITS-1:0]          decoded_count_next;
  logic [cpd_pkg::TYPE_W-1:0]     header_type;
  logic [cpd_pkg::TYPE_W-1:0]     header_type_next;
  logic [cpd_pkg::LENGTH_W-1:0]   header_length;
  logic [cpd_pkg::LENGTH_W-1:0]   header_length_next;
  logic [COUNT_BITS-1:0]          len_offset;
  logic                           in_header;
  logic                           in_length;
  logic                           short_pkt;
  logic                           bad_header;
  cpd_pkg::status_t               end_status;
  logic                           load;
  logic                           load_end;
  logic                           res_valid_next;

  assign pop = !q_status.empty && (!res_valid || !res_stall);
  assign in_header = (decoded_count < COUNT_BITS'(cpd_pkg::HEADER_BYTES));
  assign in_length = (decoded_count >= COUNT_BITS'(cpd_pkg::LEN_FIRST_INDEX)) &&
                     (decoded_count <= COUNT_BITS'(cpd_pkg::LEN_LAST_INDEX));
  assign len_offset = decoded_count - COUNT_BITS'(cpd_pkg::LEN_FIRST_INDEX);

  assign short_pkt  = cmd.truncated || in_header;
  assign bad_header = (header_type != expected_type) ||
                      (header_length == '0) ||
                      (header_length > cpd_pkg::LENGTH_W'(max_payload)) ||
                      (SUM_W'(decoded_count) !=
                       SUM_W'(cpd_pkg::HEADER_BYTES) + SUM_W'(header_length));

  always_comb begin
    priority if (cmd.kind == cpd_pkg::CMD_END_OVF) begin
      end_status = cpd_pkg::ST_OVERFLOW;
    end else if (short_pkt) begin
      end_status = cpd_pkg::ST_SHORT;
    end else if (bad_header) begin
      end_status = cpd_pkg::ST_BAD_HEADER;
    end else begin
      end_status = cpd_pkg::ST_GOOD;
    end
  end

  always_comb begin
    decoded_count_next = decoded_count;
    header_type_next   = header_type;
    header_length_next = header_length;
    load               = 1'b0;
    load_end           = 1'b0;
    if (pop) begin
      if (cmd.kind == cpd_pkg::CMD_DATA) begin
        decoded_count_next = decoded_count + COUNT_BITS'(1);
        if (in_header) begin
          if (decoded_count == COUNT_BITS'(cpd_pkg::TYPE_BYTE_INDEX)) begin
            header_type_next = cmd.data;
          end else if (in_length) begin
            header_length_next = header_length |
              (cpd_pkg::LENGTH_W'(cmd.data) << {len_offset[1:0], 3'b000});
          end
        end else begin
          load = 1'b1;
        end
      end else begin
        load               = 1'b1;
        load_end           = 1'b1;
        decoded_count_next = '0;
        header_type_next   = '0;
        header_length_next = '0;
      end
    end
  end

  assign res_valid_next = load || (res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      decoded_count <= '0;
      header_type   <= '0;
      header_length <= '0;
    end else begin
      res_valid     <= res_valid_next;
      decoded_count <= decoded_count_next;
      header_type   <= header_type_next;
      header_length <= header_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_end         <= load_end;
      data_byte      <= load_end ? 8'h00 : cmd.data;
      status         <= load_end ? end_status : cpd_pkg::ST_GOOD;
      payload_length <= load_end ? header_length : '0;
    end
  end

endmodule
`default_nettype wire

@@ src/cobs_packet_deframer_unit.sv @@
// Top level of the COBS packet deframer: registers, front end, queue, back end.
//
//   channel   direction  handshake            payload
//   rx        in         rx_valid / rx_stall  rx_byte
//   res       out        res_valid / res_stall is_end, data_byte, status, payload_length
//   cfg       in         cfg_we               cfg_index, cfg_data
//
// One byte is taken per cycle while the four-entry command queue has room.
// A payload byte is registered in the command queue and then in the result register before it leaves as a result.
// Synchronous reset clears the counters, header capture, queue and result valid.
// A stall on res fills the queue, and rx_stall rises only when the queue is full.
`default_nettype none
module cobs_packet_deframer_unit #(
  parameter int COUNT_BITS  = cpd_pkg::COUNT_BITS,
  parameter int QUEUE_DEPTH = cpd_pkg::QUEUE_DEPTH
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                rx_valid,
  output logic                               rx_stall,
  input  wire  [7:0]                         rx_byte,
  output logic                               res_valid,
  input  wire                                res_stall,
  output logic                               is_end,
  output logic [7:0]                         data_byte,
  output logic [1:0]                         status,
  output logic [cpd_pkg::LENGTH_W-1:0]       payload_length,
  input  wire                                cfg_we,
  input  wire  [cpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [cpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [cpd_pkg::TYPE_W-1:0]        expected_type;
  logic [cpd_pkg::MAX_PAYLOAD_W-1:0] max_payload;
  logic [cpd_pkg::MAX_ENCODED_W-1:0] max_encoded;

  cpd_pkg::cmd_t      push_cmd;
  cpd_pkg::cmd_t      pop_cmd;
  cpd_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type <= cpd_pkg::EXPECTED_TYPE_RESET;
      max_payload   <= cpd_pkg::MAX_PAYLOAD_RESET;
      max_encoded   <= cpd_pkg::MAX_ENCODED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpd_pkg::REG_EXPECTED_TYPE: expected_type <= cfg_data[cpd_pkg::TYPE_W-1:0];
        cpd_pkg::REG_MAX_PAYLOAD:   max_payload <= cfg_data[cpd_pkg::MAX_PAYLOAD_W-1:0];
        cpd_pkg::REG_MAX_ENCODED:   max_encoded <= cfg_data[cpd_pkg::MAX_ENCODED_W-1:0];
        default: ;
      endcase
    end
  end

  assign rx_stall = q_status.full;

  cpd_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_byte     (rx_byte),
    .max_encoded (max_encoded),
    .q_status    (q_status),
    .push        (push),
    .cmd         (push_cmd)
  );

  cpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  cpd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (pop_cmd),
    .q_status       (q_status),
    .pop            (pop),
    .expected_type  (expected_type),
    .max_payload    (max_payload),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .is_end         (is_end),
    .data_byte      (data_byte),
    .status         (status),
    .payload_length (payload_length)
  );

`ifndef ASSERT_OFF
  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_end |-> status == cpd_pkg::ST_GOOD && payload_length == '0)
    else $error("payload result carries end fields");

  a_end_data_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_end |-> data_byte == 8'h00)
    else $error("end result carries a data byte");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !q_status.empty)
    else $error("queue reports full and empty");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty && !(res_valid && res_stall))
    else $error("queue popped while result register is held");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the COBS packet deframer: random packets, predictor, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import cpd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 300000;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic                is_end;
    logic [7:0]          data;
    status_t             st;
    logic [LENGTH_W-1:0] len;
  } deframe_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   rx_valid = 1'b0;
  logic                   rx_stall;
  logic [7:0]             rx_byte = '0;
  logic                   res_valid;
  wire                    res_stall;
  logic                   is_end;
  logic [7:0]             data_byte;
  logic [1:0]             status;
  logic [LENGTH_W-1:0]    payload_length;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic draw_stall = 1'b0;
  logic hold_active = 1'b0;
  assign res_stall = draw_stall | hold_active;

  cobs_packet_deframer_unit dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_stall(res_stall),
    .is_end(is_end), .data_byte(data_byte), .status(status),
    .payload_length(payload_length),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies and packet state of the predictor
  logic [TYPE_W-1:0]        cfg_exp_type = EXPECTED_TYPE_RESET;
  logic [MAX_PAYLOAD_W-1:0] cfg_max_pay = MAX_PAYLOAD_RESET;
  logic [MAX_ENCODED_W-1:0] cfg_max_enc = MAX_ENCODED_RESET;
  logic [COUNT_BITS-1:0]    enc_cnt = '0;
  logic [7:0]               blk_left = '0;
  logic                     zero_pending = 1'b0;
  logic [COUNT_BITS-1:0]    dec_cnt = '0;
  logic [7:0]               hdr_type = '0;
  logic [LENGTH_W-1:0]      hdr_len = '0;

  deframe_result_t deframed_results[$];
  logic [7:0]      rx_pending[$];

  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          send_gap = 0;
  logic        send_calm = 1'b0;
  int          stall_left = 0;
  logic        recv_calm = 1'b0;
  int          holds_asked = 0;
  int          holds_served = 0;
  int          hold_left = 0;

  function automatic void close_packet(input status_t st);
    deframed_results.push_back('{is_end: 1'b1, data: 8'h00, st: st, len: hdr_len});
    enc_cnt = '0;
    blk_left = '0;
    zero_pending = 1'b0;
    dec_cnt = '0;
    hdr_type = '0;
    hdr_len = '0;
  endfunction

  function automatic void absorb_decoded(input logic [7:0] b);
    int idx;
    idx = int'(dec_cnt);
    dec_cnt = dec_cnt + 1'b1;
    if (idx == TYPE_BYTE_INDEX) begin
      hdr_type = b;
    end else if (idx >= LEN_FIRST_INDEX && idx <= LEN_LAST_INDEX) begin
      hdr_len[8*(idx-LEN_FIRST_INDEX) +: 8] = b;
    end else if (idx >= HEADER_BYTES) begin
      deframed_results.push_back('{is_end: 1'b0, data: b, st: ST_GOOD, len: '0});
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    if (b == DELIMITER) begin
      if (blk_left != 0 || dec_cnt < HEADER_BYTES) begin
        close_packet(ST_SHORT);
      end else if (hdr_type != cfg_exp_type || hdr_len == 0 ||
                   hdr_len > LENGTH_W'(cfg_max_pay) ||
                   64'(dec_cnt) != 64'(HEADER_BYTES) + 64'(hdr_len)) begin
        close_packet(ST_BAD_HEADER);
      end else begin
        close_packet(ST_GOOD);
      end
    end else if (enc_cnt >= cfg_max_enc || enc_cnt == '1) begin
      close_packet(ST_OVERFLOW);
    end else begin
      enc_cnt = enc_cnt + 1'b1;
      if (blk_left == 0) begin
        if (zero_pending) absorb_decoded(8'h00);
        blk_left = b - CODE_STEP;
        zero_pending = (b != FULL_BLOCK_CODE);
      end else begin
        blk_left = blk_left - 1'b1;
        absorb_decoded(b);
      end
    end
  endfunction

  function automatic logic [7:0] sparse_octet();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  function automatic octet_q_t build_packet(input logic [7:0] type_field,
                                            input logic [LENGTH_W-1:0] len_field,
                                            input int plen);
    octet_q_t raw;
    logic dense;
    dense = (plen >= 200) && ($urandom_range(0, 1) == 1);
    raw.push_back(type_field);
    repeat (LEN_FIRST_INDEX - 1) raw.push_back(sparse_octet());
    for (int i = 0; i <= LEN_LAST_INDEX - LEN_FIRST_INDEX; i++) raw.push_back(len_field[8*i +: 8]);
    repeat (plen) raw.push_back(dense ? 8'($urandom_range(1, 255)) : sparse_octet());
    return raw;
  endfunction

  // encode, optionally chop the encoded stream, then append the delimiter
  task automatic queue_cobs(input octet_q_t raw, input logic chop);
    octet_q_t enc;
    octet_q_t blk;
    int keep;
    foreach (raw[i]) begin
      if (raw[i] != 8'h00) blk.push_back(raw[i]);
      if (raw[i] == 8'h00 || blk.size() == 254) begin
        enc.push_back((raw[i] == 8'h00) ? 8'(blk.size() + 1) : FULL_BLOCK_CODE);
        foreach (blk[j]) enc.push_back(blk[j]);
        blk.delete();
      end
    end
    enc.push_back(8'(blk.size() + 1));
    foreach (blk[j]) enc.push_back(blk[j]);
    if (chop && enc.size() > 1) begin
      keep = $urandom_range(1, enc.size() - 1);
      while (enc.size() > keep) void'(enc.pop_back());
    end
    foreach (enc[i]) rx_pending.push_back(enc[i]);
    rx_pending.push_back(DELIMITER);
  endtask

  task automatic queue_packet();
    octet_q_t raw;
    int pick;
    int plen;
    int keep;
    logic [7:0] type_field;
    logic [LENGTH_W-1:0] len_field;
    pick = $urandom_range(0, 99);
    if (pick >= 88 && pick < 94) begin
      repeat ($urandom_range(1, 30)) rx_pending.push_back(sparse_octet());
      return;
    end
    plen = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 24);
    if (plen > int'(cfg_max_pay)) plen = $urandom_range(1, int'(cfg_max_pay));
    type_field = cfg_exp_type;
    len_field = LENGTH_W'(plen);
    if (pick >= 60 && pick < 68) begin
      type_field = cfg_exp_type ^ 8'($urandom_range(1, 255));
    end else if (pick >= 68 && pick < 74) begin
      len_field = ($urandom_range(0, 1) == 1) ? len_field + $urandom_range(1, 3) : len_field - 1;
    end else if (pick >= 74 && pick < 78) begin
      len_field = '0;
    end else if (pick >= 78 && pick < 82) begin
      len_field = ($urandom_range(0, 3) == 0) ? $urandom
                                              : LENGTH_W'(cfg_max_pay) + $urandom_range(1, 3);
      if (len_field < 700) plen = int'(len_field);
    end
    raw = build_packet(type_field, len_field, plen);
    if (pick >= 94) begin
      keep = $urandom_range(0, HEADER_BYTES - 1);
      while (raw.size() > keep) void'(raw.pop_back());
    end
    queue_cobs(raw, pick >= 82 && pick < 88);
  endtask

  task automatic queue_random(input int n);
    int start;
    @(negedge clk);
    start = rx_pending.size();
    while (rx_pending.size() - start < n) queue_packet();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_pending.size() != 0 || rx_valid || deframed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_EXPECTED_TYPE: cfg_exp_type = TYPE_W'(value);
      REG_MAX_PAYLOAD:   cfg_max_pay = MAX_PAYLOAD_W'(value);
      REG_MAX_ENCODED:   cfg_max_enc = MAX_ENCODED_W'(value);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : rx_driver
    logic offer;
    if (rst) begin
      rx_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = rx_valid;
      if (rx_valid && !rx_stall) begin
        deframe_byte(rx_byte);
        offer = 1'b0;
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 4);
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (rx_pending.size() != 0) begin
          rx_byte <= rx_pending.pop_front();
          offer = 1'b1;
        end
      end
      rx_valid <= offer;
    end
  end

  always @(posedge clk) begin : res_monitor
    deframe_result_t want;
    if (rst) begin
      draw_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (deframed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: is_end=%0d data=%02h status=%0d len=%0d",
                     is_end, data_byte, status, payload_length);
        end else begin
          want = deframed_results.pop_front();
          if (is_end !== want.is_end || data_byte !== want.data ||
              status !== want.st || payload_length !== want.len) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected is_end=%0d data=%02h status=%0d len=%0d,",
                       want.is_end, want.data, want.st, want.len,
                       " got is_end=%0d data=%02h status=%0d len=%0d",
                       is_end, data_byte, status, payload_length);
          end
        end
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, 4);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      draw_stall <= (stall_left != 0);
    end
  end

  // hold off the result side so the queue fills and rx_stall rises
  always @(posedge clk) begin : res_hold
    if (rst) begin
      hold_left = 0;
      hold_active <= 1'b0;
    end else begin
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      hold_active <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cobs_packet_deframer_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    rx_pending.push_back(DELIMITER);
    rx_pending.push_back(8'h05);
    rx_pending.push_back(8'h11);
    rx_pending.push_back(DELIMITER);
    rx_pending.push_back(8'h03);
    rx_pending.push_back(8'hAA);
    rx_pending.push_back(8'hBB);
    rx_pending.push_back(DELIMITER);
    queue_cobs(build_packet(cfg_exp_type, 32'd1, 1), 1'b0);
    queue_random(280);
    wait_drained();

    write_reg(REG_EXPECTED_TYPE, 255);
    write_reg(REG_MAX_PAYLOAD, 130816);
    write_reg(REG_MAX_ENCODED, 131072);
    queue_random(300);
    wait_drained();

    write_reg(REG_EXPECTED_TYPE, 0);
    write_reg(REG_MAX_PAYLOAD, 1);
    write_reg(REG_MAX_ENCODED, 12);
    queue_random(250);
    wait_drained();

    write_reg(REG_MAX_ENCODED, 0);
    queue_random(100);
    wait_drained();

    write_reg(REG_EXPECTED_TYPE, $urandom_range(1, 254));
    write_reg(REG_MAX_PAYLOAD, 40);
    write_reg(REG_MAX_ENCODED, 300);
    write_reg(REG_UNUSED, 0);
    queue_random(400);
    holds_asked++;
    wait_drained();

    write_reg(REG_MAX_PAYLOAD, $urandom_range(2, 600));
    write_reg(REG_MAX_ENCODED, $urandom_range(40, 2000));
    queue_random(350);
    wait_drained();

    mismatches += deframed_results.size();
    if (mismatches == 0) begin
      $display("cobs_packet_deframer_unit verification clean");
    end else begin
      $display("cobs_packet_deframer_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cpd_pkg.sv
src/cpd_front.sv
src/cpd_queue.sv
src/cpd_back.sv
src/cobs_packet_deframer_unit.sv
tb/sv/tb_top.sv
